// File: sv/tsa_pkg.sv
// ---------------------------------------------------------------------------
// Taylor sine package
// Shared types, constants and constant tables for the Taylor-series sine
// controller and datapath.
// ---------------------------------------------------------------------------
package tsa_pkg;

  localparam int FRAC_BITS = 28;

  // Largest number of terms that is summed; larger counts are clamped.
  localparam logic [3:0] MAX_TERMS = 4'd8;

  // Term magnitudes are held at 2^61.
  localparam logic [61:0] TERM_CAP = 62'h2000_0000_0000_0000;

  // Running sum is held within +/-2^62.
  localparam logic signed [63:0] ACC_CAP = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] ACC_MIN = -ACC_CAP;

  // Signed 48-bit output limits.
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

  // Rounding constant for a product scaled down by 2^FRAC_BITS.
  localparam logic [127:0] RND_HALF = 128'd1 << (FRAC_BITS - 1);

  // Reciprocals floor(2^64 / d) for the divisors (2k)(2k+1).
  localparam logic [64:0] TWO_POW_64 = 65'd1 << 64;
  localparam logic [63:0] RECIP_K1 = 64'(TWO_POW_64 / 65'd6);
  localparam logic [63:0] RECIP_K2 = 64'(TWO_POW_64 / 65'd20);
  localparam logic [63:0] RECIP_K3 = 64'(TWO_POW_64 / 65'd42);
  localparam logic [63:0] RECIP_K4 = 64'(TWO_POW_64 / 65'd72);
  localparam logic [63:0] RECIP_K5 = 64'(TWO_POW_64 / 65'd110);
  localparam logic [63:0] RECIP_K6 = 64'(TWO_POW_64 / 65'd156);
  localparam logic [63:0] RECIP_K7 = 64'(TWO_POW_64 / 65'd210);

  // Operand pair presented to the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_TERM,
    MUL_DIV
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQ_WAIT,
    S_SQ_DONE,
    S_TM_MUL,
    S_TM_WAIT,
    S_TM_RND,
    S_DV_MUL,
    S_DV_WAIT,
    S_DV_FIX1,
    S_DV_FIX2,
    S_SUM,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic [1:0] chunk;
    logic       acc_clr;
    logic       sq_done;
    logic       rnd;
    logic       fix1;
    logic       fix2;
    logic       sum_add;
    logic       out_load;
    logic [2:0] k;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // Divisor (2k)(2k+1) of term k.
  function automatic logic [7:0] divisor(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd1: d = 8'd6;
      3'd2: d = 8'd20;
      3'd3: d = 8'd42;
      3'd4: d = 8'd72;
      3'd5: d = 8'd110;
      3'd6: d = 8'd156;
      3'd7: d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] recip(input logic [2:0] k);
    logic [63:0] r;
    case (k)
      3'd1: r = RECIP_K1;
      3'd2: r = RECIP_K2;
      3'd3: r = RECIP_K3;
      3'd4: r = RECIP_K4;
      3'd5: r = RECIP_K5;
      3'd6: r = RECIP_K6;
      3'd7: r = RECIP_K7;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

// File: sv/tsa_datapath.sv
// ---------------------------------------------------------------------------
// Taylor sine datapath
// Shared 32x32 multiplier with a 128-bit accumulator, term and sum
// registers, reciprocal division with correction, and the result register.
// ---------------------------------------------------------------------------
module tsa_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tsa_pkg::cmd_t       cmd,
  output tsa_pkg::status_t    status,
  input  logic signed [31:0]  angle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  sine_value,
  output logic                saturated
);

  localparam int FB = tsa_pkg::FRAC_BITS;

  logic               neg;
  logic [31:0]        mag;
  logic [34:0]        x2;
  logic [61:0]        t;
  logic [61:0]        num;
  logic [61:0]        qest;
  logic [69:0]        qd;
  logic [127:0]       acc;
  logic [63:0]        prod;
  logic               pp_valid;
  logic [1:0]         pp_sh;
  logic signed [63:0] sum;
  logic               clip;

  logic [63:0]        opa;
  logic [63:0]        opb;
  logic [31:0]        a_ch;
  logic [31:0]        b_ch;
  logic [127:0]       pp_shifted;
  logic [127:0]       rnd_sum;
  logic [63:0]        r_full;
  logic               clip_t;
  logic [61:0]        r_term;
  logic [7:0]         d;
  logic [69:0]        rem;
  logic signed [63:0] t_signed;
  logic signed [63:0] sum_raw;
  logic signed [63:0] sum_sat;
  logic               clip_s;
  logic signed [63:0] out_sat;
  logic               clip_o;

  always_comb begin
    case (cmd.mul_sel)
      tsa_pkg::MUL_SQ: begin
        opa = {32'b0, mag};
        opb = {32'b0, mag};
      end
      tsa_pkg::MUL_TERM: begin
        opa = {2'b0, t};
        opb = {29'b0, x2};
      end
      tsa_pkg::MUL_DIV: begin
        opa = {2'b0, num};
        opb = tsa_pkg::recip(cmd.k);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    a_ch = cmd.chunk[1] ? opa[63:32] : opa[31:0];
    b_ch = cmd.chunk[0] ? opb[63:32] : opb[31:0];
  end

  always_comb begin
    case (pp_sh)
      2'd0: pp_shifted = {64'b0, prod};
      2'd1: pp_shifted = {32'b0, prod, 32'b0};
      2'd2: pp_shifted = {prod, 64'b0};
      default: pp_shifted = '0;
    endcase
  end

  // Round the product down by 2^FRAC_BITS and hold it at the term cap.
  always_comb begin
    rnd_sum = acc + tsa_pkg::RND_HALF;
    r_full  = rnd_sum[63+FB:FB];
    clip_t  = (|rnd_sum[127:64+FB]) || (r_full > {2'b0, tsa_pkg::TERM_CAP});
    r_term  = clip_t ? tsa_pkg::TERM_CAP : r_full[61:0];
  end

  assign d   = tsa_pkg::divisor(cmd.k);
  assign rem = {8'b0, num} - qd;

  always_comb begin
    t_signed = (neg ^ cmd.k[0]) ? (64'sd0 - $signed({2'b0, t})) : $signed({2'b0, t});
    sum_raw  = sum + t_signed;
    clip_s   = 1'b0;
    sum_sat  = sum_raw;
    if (sum_raw > tsa_pkg::ACC_CAP) begin
      sum_sat = tsa_pkg::ACC_CAP;
      clip_s  = 1'b1;
    end else if (sum_raw < tsa_pkg::ACC_MIN) begin
      sum_sat = tsa_pkg::ACC_MIN;
      clip_s  = 1'b1;
    end
  end

  always_comb begin
    clip_o  = 1'b0;
    out_sat = sum;
    if (sum > tsa_pkg::OUT_MAX) begin
      out_sat = tsa_pkg::OUT_MAX;
      clip_o  = 1'b1;
    end else if (sum < tsa_pkg::OUT_MIN) begin
      out_sat = tsa_pkg::OUT_MIN;
      clip_o  = 1'b1;
    end
  end

  // Multiplier stage and accumulator: a partial product is registered in the
  // product register and then added into the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= cmd.mul_en;
    end
    if (cmd.mul_en) begin
      prod  <= 64'(a_ch) * 64'(b_ch);
      pp_sh <= {1'b0, cmd.chunk[1]} + {1'b0, cmd.chunk[0]};
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (pp_valid) begin
      acc <= acc + pp_shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg  <= angle[31];
      mag  <= angle[31] ? (32'd0 - $unsigned(angle)) : $unsigned(angle);
      sum  <= '0;
      clip <= 1'b0;
    end
    if (cmd.sq_done) begin
      x2  <= acc[FB+34:FB] + {34'b0, acc[FB-1]};
      t   <= {30'b0, mag};
      sum <= neg ? (64'sd0 - $signed({32'b0, mag})) : $signed({32'b0, mag});
    end
    if (cmd.rnd) begin
      num <= r_term + {55'b0, d[7:1]};
      if (clip_t) begin
        clip <= 1'b1;
      end
    end
    if (cmd.fix1) begin
      qest <= acc[125:64];
      qd   <= 70'(acc[125:64]) * 70'(d);
    end
    if (cmd.fix2) begin
      t <= (rem >= {62'b0, d}) ? (qest + 62'd1) : qest;
    end
    if (cmd.sum_add) begin
      sum <= sum_sat;
      if (clip_s) begin
        clip <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      sine_value <= out_sat[47:0];
      saturated  <= clip | clip_o;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: sv/tsa_ctrl.sv
// ---------------------------------------------------------------------------
// Taylor sine controller
// Holds the term count register and sequences the datapath through the
// squaring, term multiply, division and summing steps.
// ---------------------------------------------------------------------------
module tsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [3:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  tsa_pkg::status_t status,
  output tsa_pkg::cmd_t    cmd
);

  tsa_pkg::state_t state;
  tsa_pkg::state_t state_next;
  logic [3:0]      term_count;
  logic [3:0]      n;
  logic [3:0]      n_next;
  logic [2:0]      k;
  logic [2:0]      k_next;
  logic [1:0]      cnt;
  logic [1:0]      cnt_next;
  logic            last_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tsa_pkg::S_IDLE;
      term_count <= 4'd5;
      n          <= '0;
      k          <= '0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      k     <= k_next;
      cnt   <= cnt_next;
      if (cfg_write) begin
        term_count <= cfg_data;
      end
    end
  end

  assign last_term = ({1'b0, k} + 4'd1) == n;

  always_comb begin
    state_next  = state;
    n_next      = n;
    k_next      = k;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.mul_sel = tsa_pkg::MUL_SQ;
    cmd.k       = k;
    in_stall    = 1'b1;
    case (state)
      tsa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          n_next   = (term_count > tsa_pkg::MAX_TERMS) ? tsa_pkg::MAX_TERMS : term_count;
          state_next = (term_count == 4'd0) ? tsa_pkg::S_OUT : tsa_pkg::S_SQ;
        end
      end
      tsa_pkg::S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_next  = tsa_pkg::S_SQ_WAIT;
      end
      tsa_pkg::S_SQ_WAIT: begin
        state_next = tsa_pkg::S_SQ_DONE;
      end
      tsa_pkg::S_SQ_DONE: begin
        cmd.sq_done = 1'b1;
        k_next      = 3'd1;
        cnt_next    = 2'd0;
        state_next  = (n == 4'd1) ? tsa_pkg::S_OUT : tsa_pkg::S_TM_MUL;
      end
      tsa_pkg::S_TM_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tsa_pkg::MUL_TERM;
        cmd.chunk   = cnt;
        cmd.acc_clr = (cnt == 2'd0);
        cnt_next    = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = tsa_pkg::S_TM_WAIT;
        end
      end
      tsa_pkg::S_TM_WAIT: begin
        state_next = tsa_pkg::S_TM_RND;
      end
      tsa_pkg::S_TM_RND: begin
        cmd.rnd    = 1'b1;
        state_next = tsa_pkg::S_DV_MUL;
      end
      tsa_pkg::S_DV_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tsa_pkg::MUL_DIV;
        cmd.chunk   = cnt;
        cmd.acc_clr = (cnt == 2'd0);
        cnt_next    = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = tsa_pkg::S_DV_WAIT;
        end
      end
      tsa_pkg::S_DV_WAIT: begin
        state_next = tsa_pkg::S_DV_FIX1;
      end
      tsa_pkg::S_DV_FIX1: begin
        cmd.fix1   = 1'b1;
        state_next = tsa_pkg::S_DV_FIX2;
      end
      tsa_pkg::S_DV_FIX2: begin
        cmd.fix2   = 1'b1;
        state_next = tsa_pkg::S_SUM;
      end
      tsa_pkg::S_SUM: begin
        cmd.sum_add = 1'b1;
        if (last_term) begin
          state_next = tsa_pkg::S_OUT;
        end else begin
          k_next     = k + 3'd1;
          state_next = tsa_pkg::S_TM_MUL;
        end
      end
      tsa_pkg::S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = tsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/taylor_sine_approx.sv
// ---------------------------------------------------------------------------
// Taylor-series sine approximation
// Sums the first term_count Taylor terms of sine for a Q3.28 angle and
// returns a saturated Q19.28 result.
// ---------------------------------------------------------------------------
// The block takes one signed Q3.28 angle per input transaction and returns
// one Q19.28 partial sum x - x^3/3! + x^5/5! - ... per output transaction,
// with the number of terms taken from the term_count register (reset value
// five, counts above eight act as eight, zero gives a result of zero). It
// works on one angle at a time: it accepts the angle, squares it and forms
// the first term, then works out every further term in turn and adds it to
// the running sum, and at last loads the result register once it is free.
// The per-term cost is set by the single shared 32x32
// multiplier, which needs four partial products for the term times x
// squared and four more for the division by (2k)(2k+1), done as a
// multiplication by a stored reciprocal and a one-step correction. The
// result sits in an output register, so the next angle is taken and
// computed while an earlier result waits to be taken. Each step rounds half
// up; a term above 2^61 is held there, the running sum is held within
// +/-2^62, and the final value is clipped to the signed 48-bit range, with
// saturated set whenever any of these limits was hit. The term_count
// register should be written only while the block is idle.
// ---------------------------------------------------------------------------
module taylor_sine_approx (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] sine_value,
  output logic               saturated
);

  // Commands go from the controller to the datapath, status comes back.
  tsa_pkg::cmd_t    cmd;
  tsa_pkg::status_t status;

  // The controller owns the term count register and the step sequence.
  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the multiplier, accumulator, term and sum registers,
  // and the output register with its valid flag.
  tsa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .angle      (angle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sine_value (sine_value),
    .saturated  (saturated)
  );

  // Once a transaction is accepted the block is busy in the cycle that follows.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while the previous angle was still in work");

  // The result register is only loaded when it is free to take a new value.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten while a result was waiting");

  // A loaded result is presented in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // The sequencing steps never overlap.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.sq_done, cmd.rnd, cmd.fix1, cmd.fix2,
              cmd.sum_add, cmd.out_load, cmd.mul_en}))
    else $error("overlapping datapath commands");

endmodule
